// ===== rtl/cda_pkg.sv =====
// Shared types, constants and helpers for the calendar date adder.
package cda_pkg;

    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 17;
    localparam int LDAY_W  = 5;
    localparam int AMT_W   = 16;
    localparam int ODAY_W  = 16;
    localparam int QUO_W   = 13;
    localparam int MODE_W  = 2;

    localparam logic [YEAR_W-1:0]  YEAR_MAX        = 16'hFFFF;
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;

    // Reciprocal of three scaled by 2^17, rounded up
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DAYS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MONTHS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_YEARS  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [YEAR_W-1:0]  load_year;
        logic [MONTH_W-1:0] load_month;
        logic [LDAY_W-1:0]  load_day;
        logic [AMT_W-1:0]   amount;
    } cda_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  cur_year;
        logic [MONTH_W-1:0] cur_month;
        logic [ODAY_W-1:0]  cur_day;
        logic               year_saturated;
    } cda_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic walk_step;
        logic div_mul;
        logic div_fix;
    } cda_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_more;
    } cda_sts_t;

    // Month length, no leap years
    function automatic logic [4:0] month_length(input logic [MONTH_W-1:0] m);
        logic [4:0] len;
        begin
            case (m)
                4'd2:                      len = 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== rtl/cda_ctrl.sv =====
// Sequencing state machine for the calendar date adder.
module cda_ctrl
    import cda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MODE_W-1:0] mode,
    input  cda_sts_t          sts,
    output cda_cmd_t          cmd,
    output logic              busy,
    output logic              done
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_FIX  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    case (mode)
                        MODE_DAYS:   state_next = ST_WALK;
                        MODE_MONTHS: state_next = ST_MUL;
                        default:     state_next = ST_EMIT;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (sts.walk_more)
                    cmd.walk_step = 1'b1;
                else
                    state_next = ST_EMIT;
            end
            ST_MUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_EMIT);

endmodule

// ===== rtl/cda_datapath.sv =====
// Date registers, month walk, divide-by-twelve and year saturation.
module cda_datapath
    import cda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cda_req_t req,
    input  cda_cmd_t cmd,
    output cda_sts_t sts,
    output cda_rsp_t rsp
);

    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg,   day_next;
    logic               sat_reg,   sat_next;
    logic [DAY_W-1:0]   total_reg;
    logic [QUO_W-1:0]   quo_reg;

    logic [4:0]         cur_len;
    logic [YEAR_W:0]    years_sum;
    logic [YEAR_W:0]    fix_sum;
    logic [31:0]        prod;
    logic [DAY_W-1:0]   twelve_q;
    logic [DAY_W-1:0]   rem;
    logic [QUO_W-1:0]   quo_adj;
    logic [MONTH_W-1:0] rem_month;

    assign cur_len       = month_length(month_reg);
    assign sts.walk_more = (day_reg > {12'd0, cur_len});

    // Quotient by twelve: shift right by two (divide by four), then multiply by reciprocal of three
    assign prod = {17'd0, total_reg[DAY_W-1:2]} * {16'd0, RECIP3};

    // Remainder and December fix for a zero remainder
    assign twelve_q = ({4'd0, quo_reg} << 3) + ({4'd0, quo_reg} << 2);
    assign rem      = total_reg - twelve_q;
    always_comb
    begin
        if (rem[MONTH_W-1:0] == '0)
        begin
            quo_adj   = quo_reg - 1'b1;
            rem_month = MONTHS_PER_YEAR;
        end
        else
        begin
            quo_adj   = quo_reg;
            rem_month = rem[MONTH_W-1:0];
        end
    end

    assign years_sum = {1'b0, year_reg} + {1'b0, req.amount};
    assign fix_sum   = {1'b0, year_reg} + {4'd0, quo_adj};

    // Next values of the date registers
    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        sat_next   = sat_reg;
        if (cmd.accept)
        begin
            sat_next = 1'b0;
            case (req.mode)
                MODE_LOAD:
                begin
                    year_next = req.load_year;
                    if (req.load_month == '0)
                        month_next = MONTH_JAN;
                    else if (req.load_month > MONTHS_PER_YEAR)
                        month_next = MONTHS_PER_YEAR;
                    else
                        month_next = req.load_month;
                    day_next = {12'd0, req.load_day};
                end
                MODE_DAYS:
                begin
                    day_next = day_reg + {1'b0, req.amount};
                end
                MODE_MONTHS:
                begin
                    // total stored below; year and month follow the divide
                end
                MODE_YEARS:
                begin
                    if (years_sum[YEAR_W])
                    begin
                        year_next = YEAR_MAX;
                        sat_next  = 1'b1;
                    end
                    else
                        year_next = years_sum[YEAR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.walk_step)
        begin
            day_next = day_reg - {12'd0, cur_len};
            if (month_reg == MONTHS_PER_YEAR)
            begin
                month_next = MONTH_JAN;
                if (year_reg == YEAR_MAX)
                    sat_next = 1'b1;
                else
                    year_next = year_reg + 1'b1;
            end
            else
                month_next = month_reg + 1'b1;
        end
        else if (cmd.div_fix)
        begin
            month_next = rem_month;
            if (fix_sum[YEAR_W])
            begin
                year_next = YEAR_MAX;
                sat_next  = 1'b1;
            end
            else
                year_next = fix_sum[YEAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= '0;
            month_reg <= MONTH_JAN;
            day_reg   <= {{(DAY_W-1){1'b0}}, 1'b1};
            sat_reg   <= 1'b0;
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            sat_reg   <= sat_next;
        end
    end

    // Month-add operands, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            total_reg <= {1'b0, req.amount} + {13'd0, month_reg};
        if (cmd.div_mul)
            quo_reg <= prod[RECIP3_SHIFT+QUO_W-1:RECIP3_SHIFT];
    end

    assign rsp.cur_year       = year_reg;
    assign rsp.cur_month      = month_reg;
    assign rsp.cur_day        = day_reg[ODAY_W-1:0];
    assign rsp.year_saturated = sat_reg;

endmodule

// ===== rtl/calendar_date_adder_unit.sv =====
// Load, add years: straight to EMIT; add months: MUL, FIX, EMIT; add days: WALK, then EMIT.
// Adding days walks one month per cycle in the datapath: at most about 2160 steps.
// One request at a time; busy stays high through the result strobe.
// The result is shown for one cycle with done; the receiver cannot stall it.
// Reset (rst_n low, asynchronous) sets the date to year 0, month 1, day 1.
module calendar_date_adder_unit
    import cda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cda_req_t request,
    output logic     busy,
    output logic     done,
    output cda_rsp_t result
);

    cda_cmd_t cmd;
    cda_sts_t sts;

    cda_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (request.mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    cda_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (request),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (result)
    );

endmodule
